FILE: rtl/core/cube_map_face_select_assert.svh
// Assertion macros for the cube map face select checker.
// Clock and active-low reset are passed in by the user of each macro.
`ifndef CUBE_MAP_FACE_SELECT_ASSERT_SVH
`define CUBE_MAP_FACE_SELECT_ASSERT_SVH

// same-cycle implication
`define CMFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication after a fixed number of cycles
`define CMFS_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/cmfs_pkg.sv
// Shared types and constants for the cube map face select pipeline.
// No dependencies.
package cmfs_pkg;

	localparam int COMP_BITS  = 24;
	localparam int FRAC_BITS  = 16;
	localparam int MAG_W      = COMP_BITS;
	localparam int MIN_W      = COMP_BITS + 1;
	localparam int NUM_W      = COMP_BITS + 2;
	localparam int REM_W      = MAG_W + 1;
	localparam int QUO_W      = FRAC_BITS + 1;
	localparam int COORD_W    = FRAC_BITS + 1;
	localparam int SPS        = 3;
	localparam int DIV_STAGES = (QUO_W + SPS - 1) / SPS;
	localparam int LATENCY    = DIV_STAGES + 3;

	localparam logic [2:0] FACE_POS_X = 3'd0;
	localparam logic [2:0] FACE_NEG_X = 3'd1;
	localparam logic [2:0] FACE_POS_Y = 3'd2;
	localparam logic [2:0] FACE_NEG_Y = 3'd3;
	localparam logic [2:0] FACE_POS_Z = 3'd4;
	localparam logic [2:0] FACE_NEG_Z = 3'd5;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_DIV  = 2'd0;
	localparam mode_t MODE_ZERO = 2'd1;
	localparam mode_t MODE_ONE  = 2'd2;
	localparam mode_t MODE_HALF = 2'd3;

	localparam logic [COORD_W-1:0] COORD_ONE  = COORD_W'(1) << FRAC_BITS;
	localparam logic [COORD_W-1:0] COORD_HALF = COORD_W'(1) << (FRAC_BITS - 1);

	typedef struct packed {
		logic signed [COMP_BITS-1:0] dir_x;
		logic signed [COMP_BITS-1:0] dir_y;
		logic signed [COMP_BITS-1:0] dir_z;
	} dir_t;

	typedef struct packed {
		logic [2:0]         face;
		logic [COORD_W-1:0] coord_s;
		logic [COORD_W-1:0] coord_t;
		logic               zero_vector;
	} result_t;

	typedef struct packed {
		logic [2:0]              face;
		logic                    zero_vector;
		logic [MAG_W-1:0]        major;
		logic signed [MIN_W-1:0] minor_s;
		logic signed [MIN_W-1:0] minor_t;
	} sel_t;

	typedef struct packed {
		logic [2:0] face;
		logic       zero_vector;
		mode_t      mode_s;
		mode_t      mode_t_;
	} meta_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} lane_t;

	typedef struct packed {
		lane_t            s;
		lane_t            t;
		logic [MAG_W-1:0] major;
	} div_t;

endpackage

FILE: rtl/core/cube_map_face_select.sv
// Cube map face select top level: face pick and s/t face coordinates.
// Depends on cmfs_pkg, cmfs_face_sel, cmfs_prep, cmfs_divider, cmfs_coord.
//
//   channel   handshake          payload
//   input     start / busy       dir    (dir_t)
//   output    done (strobe)      result (result_t)
//
// One transaction enters per cycle; busy stays low. The pipeline registers are
// face select, numerator setup, DIV_STAGES (6) divider stages of up to SPS (3)
// quotient bits each, and the output register. Reset clears the valid bits only.
// Results leave in order, one done pulse per accepted transaction.
module cube_map_face_select
	import cmfs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  dir_t    dir,
	output logic    done,
	output result_t result
);

	logic  vld_s1, vld_s2, vld_dv;
	sel_t  sel_s1;
	meta_t meta_s2, meta_dv;
	div_t  div_s2, div_dv;

	assign busy = 1'b0;

	cmfs_face_sel u_face_sel (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (start & ~busy),
		.dir    (dir),
		.vld_s1 (vld_s1),
		.sel_s1 (sel_s1)
	);

	cmfs_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s1  (vld_s1),
		.sel_s1  (sel_s1),
		.vld_s2  (vld_s2),
		.meta_s2 (meta_s2),
		.div_s2  (div_s2)
	);

	cmfs_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (vld_s2),
		.meta_in  (meta_s2),
		.div_in   (div_s2),
		.vld_out  (vld_dv),
		.meta_out (meta_dv),
		.div_out  (div_dv)
	);

	cmfs_coord u_coord (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_dv),
		.meta   (meta_dv),
		.div    (div_dv),
		.done   (done),
		.result (result)
	);

endmodule

FILE: rtl/core/cmfs_face_sel.sv
// Stage 1: magnitude compare, face pick and minor-axis select.
// Depends on cmfs_pkg.
module cmfs_face_sel
	import cmfs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic vld,
	input  dir_t dir,
	output logic vld_s1,
	output sel_t sel_s1
);

	logic [MAG_W-1:0]        ax, ay, az;
	logic signed [MIN_W-1:0] ex, ey, ez;
	sel_t                    sel;

	always_comb begin
		ax = dir.dir_x[COMP_BITS-1] ? MAG_W'(~dir.dir_x + 1'b1) : MAG_W'(dir.dir_x);
		ay = dir.dir_y[COMP_BITS-1] ? MAG_W'(~dir.dir_y + 1'b1) : MAG_W'(dir.dir_y);
		az = dir.dir_z[COMP_BITS-1] ? MAG_W'(~dir.dir_z + 1'b1) : MAG_W'(dir.dir_z);
		ex = MIN_W'(dir.dir_x);
		ey = MIN_W'(dir.dir_y);
		ez = MIN_W'(dir.dir_z);
		sel.zero_vector = (ax == '0) && (ay == '0) && (az == '0);
		if (ax > ay && ax > az) begin
			sel.major   = ax;
			sel.minor_t = -ey;
			if (!dir.dir_x[COMP_BITS-1]) begin
				sel.face    = FACE_POS_X;
				sel.minor_s = -ez;
			end else begin
				sel.face    = FACE_NEG_X;
				sel.minor_s = ez;
			end
		end else if (ay > ax && ay > az) begin
			sel.major   = ay;
			sel.minor_s = ex;
			if (!dir.dir_y[COMP_BITS-1]) begin
				sel.face    = FACE_POS_Y;
				sel.minor_t = ez;
			end else begin
				sel.face    = FACE_NEG_Y;
				sel.minor_t = -ez;
			end
		end else begin
			sel.major   = az;
			sel.minor_t = -ey;
			if (!dir.dir_z[COMP_BITS-1]) begin
				sel.face    = FACE_POS_Z;
				sel.minor_s = ex;
			end else begin
				sel.face    = FACE_NEG_Z;
				sel.minor_s = -ex;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		sel_s1 <= sel;
	end

endmodule

FILE: rtl/core/cmfs_prep.sv
// Stage 2: numerator forming, clamp classification and divider setup.
// Depends on cmfs_pkg.
module cmfs_prep
	import cmfs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld_s1,
	input  sel_t  sel_s1,
	output logic  vld_s2,
	output meta_t meta_s2,
	output div_t  div_s2
);

	logic signed [NUM_W-1:0] num_s, num_t, maj_ext, twice;
	meta_t                   meta;
	div_t                    div;

	function automatic mode_t classify(
		input logic signed [NUM_W-1:0] num,
		input logic signed [MIN_W-1:0] minor,
		input logic signed [NUM_W-1:0] two_m,
		input logic                    maj_zero
	);
		mode_t m;
		if (maj_zero) begin
			if (minor == '0)
				m = MODE_HALF;
			else if (minor[MIN_W-1])
				m = MODE_ZERO;
			else
				m = MODE_ONE;
		end else if (num[NUM_W-1] || num == '0) begin
			m = MODE_ZERO;
		end else if (num >= two_m) begin
			m = MODE_ONE;
		end else begin
			m = MODE_DIV;
		end
		return m;
	endfunction

	always_comb begin
		maj_ext = $signed({2'b00, sel_s1.major});
		twice   = $signed({1'b0, sel_s1.major, 1'b0});
		num_s   = NUM_W'(sel_s1.minor_s) + maj_ext;
		num_t   = NUM_W'(sel_s1.minor_t) + maj_ext;
		meta.face        = sel_s1.face;
		meta.zero_vector = sel_s1.zero_vector;
		if (sel_s1.zero_vector) begin
			meta.mode_s  = MODE_HALF;
			meta.mode_t_ = MODE_HALF;
		end else begin
			meta.mode_s  = classify(num_s, sel_s1.minor_s, twice, sel_s1.major == '0);
			meta.mode_t_ = classify(num_t, sel_s1.minor_t, twice, sel_s1.major == '0);
		end
		div.s.rem = num_s[REM_W-1:0];
		div.s.quo = '0;
		div.t.rem = num_t[REM_W-1:0];
		div.t.quo = '0;
		div.major = sel_s1.major;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		meta_s2 <= meta;
		div_s2  <= div;
	end

endmodule

FILE: rtl/core/cmfs_divider.sv
// Pipelined restoring divider: num / major to QUO_W quotient bits, both
// coordinates side by side, up to SPS bits per stage. Depends on cmfs_pkg.
module cmfs_divider
	import cmfs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld_in,
	input  meta_t meta_in,
	input  div_t  div_in,
	output logic  vld_out,
	output meta_t meta_out,
	output div_t  div_out
);

	logic  chain_vld  [DIV_STAGES+1];
	meta_t chain_meta [DIV_STAGES+1];
	div_t  chain_div  [DIV_STAGES+1];

	function automatic lane_t div_step(input lane_t l, input logic [MAG_W-1:0] m);
		lane_t            o;
		logic             ge;
		logic [REM_W-1:0] d;
		ge    = l.rem >= {1'b0, m};
		d     = ge ? l.rem - {1'b0, m} : l.rem;
		o.rem = {d[REM_W-2:0], 1'b0};
		o.quo = {l.quo[QUO_W-2:0], ge};
		return o;
	endfunction

	assign chain_vld[0]  = vld_in;
	assign chain_meta[0] = meta_in;
	assign chain_div[0]  = div_in;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic  vld_s;
		meta_t meta_s;
		div_t  div_s;
		div_t  nxt;

		always_comb begin
			nxt = chain_div[g];
			for (int k = 0; k < SPS; k++) begin
				if (g * SPS + k < QUO_W) begin
					nxt.s = div_step(nxt.s, nxt.major);
					nxt.t = div_step(nxt.t, nxt.major);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= 1'b0;
			end else begin
				vld_s <= chain_vld[g];
			end
		end

		always_ff @(posedge clk) begin
			meta_s <= chain_meta[g];
			div_s  <= nxt;
		end

		assign chain_vld[g+1]  = vld_s;
		assign chain_meta[g+1] = meta_s;
		assign chain_div[g+1]  = div_s;
	end

	assign vld_out  = chain_vld[DIV_STAGES];
	assign meta_out = chain_meta[DIV_STAGES];
	assign div_out  = chain_div[DIV_STAGES];

endmodule

FILE: rtl/core/cmfs_coord.sv
// Final stage: quotient rounding, clamp select and result register.
// Depends on cmfs_pkg.
module cmfs_coord
	import cmfs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    vld,
	input  meta_t   meta,
	input  div_t    div,
	output logic    done,
	output result_t result
);

	logic    done_q;
	result_t result_q;
	result_t res;

	function automatic logic [COORD_W-1:0] pick(input mode_t m, input logic [QUO_W-1:0] q);
		logic [QUO_W:0]     rnd;
		logic [COORD_W-1:0] c;
		rnd = {1'b0, q} + 1'b1;
		case (m)
			MODE_ZERO: c = '0;
			MODE_ONE:  c = COORD_ONE;
			MODE_HALF: c = COORD_HALF;
			default:   c = COORD_W'(rnd >> 1);
		endcase
		return c;
	endfunction

	always_comb begin
		res.face        = meta.face;
		res.zero_vector = meta.zero_vector;
		res.coord_s     = pick(meta.mode_s, div.s.quo);
		res.coord_t     = pick(meta.mode_t_, div.t.quo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: rtl/core/cmfs_checker.sv
// Port-level checker for cube_map_face_select, bound to the top level.
// Depends on cmfs_pkg and cube_map_face_select_assert.svh.
`include "cube_map_face_select_assert.svh"

module cmfs_checker
	import cmfs_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	logic xfer_in, zero_ok, range_ok;

	assign xfer_in  = start && !busy;
	assign zero_ok  = result.face == FACE_POS_Z && result.coord_s == COORD_HALF
		&& result.coord_t == COORD_HALF;
	assign range_ok = result.face <= FACE_NEG_Z && result.coord_s <= COORD_ONE
		&& result.coord_t <= COORD_ONE;

	`CMFS_ASSERT_DLY(a_latency, clk, arst_n, xfer_in, LATENCY, done, "transaction lost")
	`CMFS_ASSERT_IMP(a_no_spurious, clk, arst_n, done, $past(xfer_in, LATENCY), "spurious result")
	`CMFS_ASSERT_IMP(a_zero_vec, clk, arst_n, done && result.zero_vector, zero_ok, "bad zero vector")
	`CMFS_ASSERT_IMP(a_range, clk, arst_n, done, range_ok, "result out of range")

endmodule

bind cube_map_face_select cmfs_checker u_cmfs_checker (.*);

FILE: verif/testbench.sv
// Self-checking testbench for cube_map_face_select: directed and random direction lookups.
// Predicts face and s/t coordinates per transaction and checks each done strobe in order.
// Depends on cmfs_pkg and the cube_map_face_select RTL.
module testbench;
	import cmfs_pkg::*;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int RANDOM_ITEMS = 1650;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	dir_t    dir;
	logic    done;
	result_t result;

	result_t pending_lookups [$];
	int      errors = 0;
	int      cycles = 0;
	int      lookups_sent = 0;
	int      lookups_checked = 0;
	int      zero_hits = 0;
	int      face_hits [6] = '{default: 0};

	cube_map_face_select u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.dir    (dir),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// (minor / major + 1) / 2 in Q1.FRAC_BITS, rounded half up, clamped to 0..1.0
	function automatic logic [COORD_W-1:0] scale_coord(longint minor, longint major);
		longint num;
		longint den;
		if (major == 0)
			return (minor > 0) ? COORD_ONE : ((minor < 0) ? '0 : COORD_HALF);
		num = minor + major;
		den = 2 * major;
		if (num <= 0)
			return '0;
		if (num >= den)
			return COORD_ONE;
		return COORD_W'(((num << FRAC_BITS) + major) / den);
	endfunction

	function automatic result_t select_face(dir_t d);
		result_t r;
		longint  x, y, z, ax, ay, az, major, sc, tc;
		x  = longint'(d.dir_x);
		y  = longint'(d.dir_y);
		z  = longint'(d.dir_z);
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = (z < 0) ? -z : z;
		if (ax > ay && ax > az) begin
			major = ax;
			tc    = -y;
			r.face = (x >= 0) ? FACE_POS_X : FACE_NEG_X;
			sc     = (x >= 0) ? -z : z;
		end else if (ay > ax && ay > az) begin
			major = ay;
			sc    = x;
			r.face = (y >= 0) ? FACE_POS_Y : FACE_NEG_Y;
			tc     = (y >= 0) ? z : -z;
		end else begin
			major = az;
			tc    = -y;
			r.face = (z >= 0) ? FACE_POS_Z : FACE_NEG_Z;
			sc     = (z >= 0) ? x : -x;
		end
		r.zero_vector = (x == 0 && y == 0 && z == 0);
		if (r.zero_vector) begin
			r.coord_s = COORD_HALF;
			r.coord_t = COORD_HALF;
		end else begin
			r.coord_s = scale_coord(sc, major);
			r.coord_t = scale_coord(tc, major);
		end
		return r;
	endfunction

	// accepted transactions in, done strobes checked against the oldest prediction
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && start === 1'b1 && busy === 1'b0) begin
			exp_r = select_face(dir);
			pending_lookups.push_back(exp_r);
			lookups_sent++;
			if (exp_r.zero_vector)
				zero_hits++;
			if (exp_r.face < 6)
				face_hits[exp_r.face]++;
		end
		if (arst_n && done === 1'b1) begin
			if (pending_lookups.size() == 0) begin
				$error("result with no transaction pending: face %0d s %0d t %0d",
					result.face, result.coord_s, result.coord_t);
				errors++;
			end else begin
				exp_r = pending_lookups.pop_front();
				lookups_checked++;
				if (result.face !== exp_r.face) begin
					$error("face: expected %0d, got %0d", exp_r.face, result.face);
					errors++;
				end
				if (result.coord_s !== exp_r.coord_s) begin
					$error("coord_s: expected %0d, got %0d", exp_r.coord_s, result.coord_s);
					errors++;
				end
				if (result.coord_t !== exp_r.coord_t) begin
					$error("coord_t: expected %0d, got %0d", exp_r.coord_t, result.coord_t);
					errors++;
				end
				if (result.zero_vector !== exp_r.zero_vector) begin
					$error("zero_vector: expected %0d, got %0d",
						exp_r.zero_vector, result.zero_vector);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_lookup(input dir_t d, input int max_gap);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		dir   <= d;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	task automatic send_xyz(input int x, input int y, input int z);
		dir_t d;
		d.dir_x = COMP_BITS'(x);
		d.dir_y = COMP_BITS'(y);
		d.dir_z = COMP_BITS'(z);
		send_lookup(d, 3);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_zero_vector();
		send_xyz(0, 0, 0);
	endtask

	task automatic test_axis_faces();
		send_xyz(65536, 0, 0);
		send_xyz(-65536, 0, 0);
		send_xyz(0, 65536, 0);
		send_xyz(0, -65536, 0);
		send_xyz(0, 0, 65536);
		send_xyz(0, 0, -65536);
		send_xyz(1, 0, 0);
		send_xyz(-1, 0, 0);
		send_xyz(0, 0, -1);
		send_xyz(-8388608, 0, 0);
	endtask

	task automatic test_extremes();
		send_xyz(8388607, -8388608, 0);
		send_xyz(-8388608, 8388607, 8388607);
		send_xyz(8388607, 8388607, 8388607);
		send_xyz(-8388608, -8388608, -8388608);
	endtask

	// no strict maximum falls back to Z; zero major when |x| = |y| and z = 0
	task automatic test_ties();
		send_xyz(100, 100, 50);
		send_xyz(100, 50, -100);
		send_xyz(0, 3, -3);
		send_xyz(5, 5, 0);
		send_xyz(-5, 5, 0);
		send_xyz(8388607, -8388607, 0);
	endtask

	task automatic test_rounding();
		send_xyz(3, 1, 1);
		send_xyz(3, -1, 2);
		send_xyz(7, 3, -5);
	endtask

	function automatic dir_t random_dir();
		dir_t d;
		logic signed [COMP_BITS-1:0] c [3];
		int mode, m, k, sh;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++)
			c[i] = COMP_BITS'($urandom());
		case (mode)
			4, 5: begin
				for (int i = 0; i < 3; i++)
					c[i] = COMP_BITS'(int'($urandom_range(0, 8)) - 4);
			end
			6: begin
				sh = $urandom_range(0, 22);
				m  = ($urandom_range(1, 8388607) >> sh) | 1;
				for (int i = 0; i < 3; i++)
					c[i] = COMP_BITS'($urandom_range(0, 1) ? m : -m);
				k = $urandom_range(0, 3);
				if (k < 3)
					c[k] = COMP_BITS'(($urandom_range(0, 1) ? 1 : -1)
						* int'($urandom_range(0, m - 1)));
			end
			7: begin
				k = $urandom_range(0, 2);
				m = $urandom_range(1, 8388607) >> $urandom_range(0, 20);
				if (m == 0)
					m = 1;
				for (int i = 0; i < 3; i++) begin
					if ($urandom_range(0, 1))
						c[i] = COMP_BITS'((m > 3) ? m - int'($urandom_range(1, 3)) : 0);
					else
						c[i] = COMP_BITS'($urandom_range(0, m - 1));
					if ($urandom_range(0, 1))
						c[i] = -c[i];
				end
				c[k] = COMP_BITS'($urandom_range(0, 1) ? m : -m);
			end
			8: begin
				for (int i = 0; i < 3; i++)
					c[i] = c[i] >>> $urandom_range(0, 23);
			end
			9: begin
				m = $urandom_range(0, 8388607) >> $urandom_range(0, 22);
				c[0] = COMP_BITS'($urandom_range(0, 1) ? m : -m);
				c[1] = COMP_BITS'($urandom_range(0, 1) ? m : -m);
				c[2] = '0;
			end
			default: ;
		endcase
		d.dir_x = c[0];
		d.dir_y = c[1];
		d.dir_z = c[2];
		return d;
	endfunction

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				wait_idle();
			send_lookup(random_dir(), ((i % 200) < 40) ? 0 : 3);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start  <= 1'b0;
		dir    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_vector();
		test_axis_faces();
		test_extremes();
		test_ties();
		test_rounding();
		wait_idle();
		test_random(RANDOM_ITEMS);

		wait_idle();
		repeat (LATENCY + 4) @(posedge clk);
		if (pending_lookups.size() != 0) begin
			$error("%0d transactions never produced a result", pending_lookups.size());
			errors++;
		end

		$display("Lookups: %0d sent, %0d checked, %0d zero vectors.",
			lookups_sent, lookups_checked, zero_hits);
		$display("Faces +X -X +Y -Y +Z -Z: %0d %0d %0d %0d %0d %0d.",
			face_hits[0], face_hits[1], face_hits[2],
			face_hits[3], face_hits[4], face_hits[5]);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
